// File: rtl/assert_macros.svh
// Assertion helpers for the top module. The clock and the reset are taken by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, ignored while reset is held.
`define VIE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define VIE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/vie_pkg.sv
`default_nettype none

package vie_pkg;

    localparam int unsigned HDR_LEN      = 6;
    localparam int unsigned STAGE_DEPTH  = 30;
    localparam int unsigned STAGE_AW     = 5;
    localparam int unsigned NAME_OFS     = 10;
    localparam int unsigned NAME_HALF    = 8;

    localparam logic [7:0] TAG_DATA      = 8'h01;
    localparam logic [7:0] TAG_DATA_LEN  = 8'd30;
    localparam logic [7:0] TAG_FREQ      = 8'h05;
    localparam logic [7:0] TAG_FREQ_LEN  = 8'd2;
    localparam logic [7:0] POS_MAX       = 8'hFF;

    // Tag walk phases; values of 2 and up index the value bytes.
    localparam logic [8:0] PH_TYPE       = 9'd0;
    localparam logic [8:0] PH_LEN        = 9'd1;
    localparam logic [8:0] PH_VALUE      = 9'd2;

    localparam int unsigned OUT_DATA_W   = 232;

    typedef logic [STAGE_DEPTH-1:0][7:0] t_stage;

    typedef struct packed {
        logic                we;
        logic [STAGE_AW-1:0] addr;
        logic [7:0]          data;
    } t_stage_wr;

    typedef struct packed {
        logic        valid_res;
        logic [7:0]  flags_first;
        logic [7:0]  flags_second;
        logic [15:0] max_receive_unit;
        logic [15:0] frame_cap;
        logic [15:0] frequency;
        logic [31:0] version_word;
        logic        version_present;
        logic [63:0] name_high;
        logic [63:0] name_low;
        logic        name_present;
    } t_result;

    // Fixed element header 00 0C 42 00 00 00.
    function automatic logic [7:0] magic_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd1:    b = 8'h0C;
            3'd2:    b = 8'h42;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/vendor_ie_tlv_parser.sv
// channel   | dir | signals                         | per transfer
// ----------+-----+---------------------------------+--------------------------------
// s_axis    | in  | tvalid tready tdata[7:0] tlast  | one element byte, tlast = final
// m_axis    | out | tvalid tready tdata tuser       | one parse result per element
//
// One byte is taken per cycle; the result of an element appears in the cycle
// after its tlast byte is taken, from a single output register.
// Byte input stalls only while that register holds a result not yet taken.
// Reset (synchronous, active low) clears the parser state and the output
// valid; every element end returns the parser to the same state.
`default_nettype none

module vendor_ie_tlv_parser
    import vie_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire  [7:0]            i_s_axis_tdata,   // data_byte
    input  wire                   i_s_axis_tlast,   // last_byte
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // flags_first[7:0] flags_second[15:8] max_receive_unit[31:16]
    // frame_cap[47:32] frequency[63:48] version_word[95:64]
    // version_present[96] name_high[160:97] name_low[224:161]
    // name_present[225] zero[231:226]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tuser    // valid_res
);

`include "assert_macros.svh"

    logic      w_accept;
    logic      w_free;
    t_stage    w_stage;
    t_stage_wr w_stage_wr;
    t_result   w_result;
    t_result   w_out_res;

    assign o_s_axis_tready = w_free;
    assign w_accept        = i_s_axis_tvalid && w_free;

    vie_stage u_stage (
        .i_clk   (i_clk),
        .i_wr    (w_stage_wr),
        .o_stage (w_stage)
    );

    vie_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_data     (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .i_stage    (w_stage),
        .o_stage_wr (w_stage_wr),
        .o_result   (w_result)
    );

    vie_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept && i_s_axis_tlast),
        .i_result (w_result),
        .i_take   (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_free   (w_free),
        .o_result (w_out_res)
    );

    assign o_m_axis_tuser = w_out_res.valid_res;
    assign o_m_axis_tdata = {6'd0,
                             w_out_res.name_present,
                             w_out_res.name_low,
                             w_out_res.name_high,
                             w_out_res.version_present,
                             w_out_res.version_word,
                             w_out_res.frequency,
                             w_out_res.frame_cap,
                             w_out_res.max_receive_unit,
                             w_out_res.flags_second,
                             w_out_res.flags_first};

    `VIE_ASSERT(a_stall_blocks_input, o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready, "input taken while result stalled")
    `VIE_ASSERT(a_last_gives_result, w_accept && i_s_axis_tlast |=> o_m_axis_tvalid, "element end gave no result")
    `VIE_ASSERT(a_invalid_is_zero, o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0, "bad element carries data")
    `VIE_ASSERT(a_name_needs_version, o_m_axis_tvalid && w_out_res.name_present |-> w_out_res.version_present, "name kept without version")

endmodule

`default_nettype wire

// File: rtl/vie_stage.sv
`default_nettype none

module vie_stage
    import vie_pkg::*;
(
    input  wire       i_clk,
    input  t_stage_wr i_wr,
    output t_stage    o_stage
);

    t_stage r_stage;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_stage[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

// File: rtl/vie_parse.sv
`default_nettype none

module vie_parse
    import vie_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_accept,
    input  wire  [7:0] i_data,
    input  wire        i_last,
    input  t_stage     i_stage,
    output t_stage_wr  o_stage_wr,
    output t_result    o_result
);

    logic [7:0]  r_pos, n_pos;
    logic        r_magic, n_magic;
    logic [8:0]  r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_flags1, n_flags1;
    logic [7:0]  r_flags2, n_flags2;
    logic [15:0] r_mru, n_mru;
    logic [15:0] r_flim, n_flim;
    logic [15:0] r_freq, n_freq;
    logic [31:0] r_ver, n_ver;
    logic        r_ver_ok, n_ver_ok;
    logic [63:0] r_name_hi, n_name_hi;
    logic [63:0] r_name_lo, n_name_lo;
    logic        r_name_ok, n_name_ok;

    logic [8:0]  w_idx;
    logic        w_done;
    logic        w_apply_data;
    logic        w_apply_freq;
    logic [63:0] w_name_hi;
    logic [63:0] w_name_lo;

    assign w_idx = r_phase - PH_VALUE;

    always_comb begin
        w_name_hi = '0;
        w_name_lo = '0;
        for (int k = 0; k < NAME_HALF; k++) begin
            w_name_hi = {w_name_hi[55:0], i_stage[NAME_OFS + k]};
            w_name_lo = {w_name_lo[55:0], i_stage[NAME_OFS + NAME_HALF + k]};
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_magic    = r_magic;
        n_phase    = r_phase;
        n_type     = r_type;
        n_len      = r_len;
        w_done     = 1'b0;
        o_stage_wr = '{we: 1'b0, addr: w_idx[STAGE_AW-1:0], data: i_data};

        if (r_pos != POS_MAX) begin
            n_pos = r_pos + 8'd1;
            if (r_pos < 8'(HDR_LEN)) begin
                if (i_data != magic_byte(r_pos[2:0])) begin
                    n_magic = 1'b0;
                end
            end else if (r_phase == PH_TYPE) begin
                n_type  = i_data;
                n_phase = PH_LEN;
            end else if (r_phase == PH_LEN) begin
                // zero-length tag ends here and changes nothing
                n_len   = i_data;
                n_phase = (i_data == 8'd0) ? PH_TYPE : PH_VALUE;
            end else begin
                o_stage_wr.we = i_accept && (w_idx < 9'(STAGE_DEPTH));
                if ((w_idx + 9'd1) >= {1'b0, r_len}) begin
                    w_done  = 1'b1;
                    n_phase = PH_TYPE;
                end else begin
                    n_phase = r_phase + 9'd1;
                end
            end
        end
    end

    assign w_apply_data = w_done && (r_type == TAG_DATA) && (r_len == TAG_DATA_LEN);
    assign w_apply_freq = w_done && (r_type == TAG_FREQ) && (r_len == TAG_FREQ_LEN);

    always_comb begin
        n_flags1  = r_flags1;
        n_flags2  = r_flags2;
        n_mru     = r_mru;
        n_flim    = r_flim;
        n_freq    = r_freq;
        n_ver     = r_ver;
        n_ver_ok  = r_ver_ok;
        n_name_hi = r_name_hi;
        n_name_lo = r_name_lo;
        n_name_ok = r_name_ok;
        if (w_apply_data) begin
            n_flags1 = i_stage[0];
            n_flags2 = i_stage[1];
            n_mru    = {i_stage[9], i_stage[8]};
            n_flim   = {i_stage[27], i_stage[26]};
            if (!r_ver_ok) begin
                n_ver    = {i_stage[7], i_stage[6], i_stage[5], i_stage[4]};
                n_ver_ok = 1'b1;
            end
            if (!r_name_ok && (i_stage[NAME_OFS] != 8'd0)) begin
                n_name_hi = w_name_hi;
                n_name_lo = w_name_lo;
                n_name_ok = 1'b1;
            end
        end
        if (w_apply_freq) begin
            // second value byte is the one arriving now
            n_freq = {i_data, i_stage[0]};
        end
    end

    always_comb begin
        o_result = '0;
        if (n_magic && (n_pos >= 8'(HDR_LEN))) begin
            o_result.valid_res        = 1'b1;
            o_result.flags_first      = n_flags1;
            o_result.flags_second     = n_flags2;
            o_result.max_receive_unit = n_mru;
            o_result.frame_cap        = n_flim;
            o_result.frequency        = n_freq;
            o_result.version_word     = n_ver;
            o_result.version_present  = n_ver_ok;
            o_result.name_high        = n_name_hi;
            o_result.name_low         = n_name_lo;
            o_result.name_present     = n_name_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_pos     <= '0;
            r_magic   <= 1'b1;
            r_phase   <= PH_TYPE;
            r_type    <= '0;
            r_len     <= '0;
            r_flags1  <= '0;
            r_flags2  <= '0;
            r_mru     <= '0;
            r_flim    <= '0;
            r_freq    <= '0;
            r_ver     <= '0;
            r_ver_ok  <= 1'b0;
            r_name_hi <= '0;
            r_name_lo <= '0;
            r_name_ok <= 1'b0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_magic   <= n_magic;
            r_phase   <= n_phase;
            r_type    <= n_type;
            r_len     <= n_len;
            r_flags1  <= n_flags1;
            r_flags2  <= n_flags2;
            r_mru     <= n_mru;
            r_flim    <= n_flim;
            r_freq    <= n_freq;
            r_ver     <= n_ver;
            r_ver_ok  <= n_ver_ok;
            r_name_hi <= n_name_hi;
            r_name_lo <= n_name_lo;
            r_name_ok <= n_name_ok;
        end
    end

endmodule

`default_nettype wire

// File: rtl/vie_out.sv
`default_nettype none

module vie_out
    import vie_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_load,
    input  t_result i_result,
    input  wire     i_take,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // free when empty or when the held result leaves this cycle
    assign o_free = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: sim/vendor_ie_tlv_parser_tb.sv
`default_nettype none

module vendor_ie_tlv_parser_tb
    import vie_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam logic [7:0] IE_MAGIC [HDR_LEN] = '{8'h00, 8'h0C, 8'h42, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] TAG_OTHER = 8'h02;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = '0;    // data_byte
    logic                  i_s_axis_tlast = 1'b0;  // last_byte
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // flags_first[7:0] flags_second[15:8] max_receive_unit[31:16]
    // frame_cap[47:32] frequency[63:48] version_word[95:64]
    // version_present[96] name_high[160:97] name_low[224:161]
    // name_present[225] zero[231:226]
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;         // valid_res

    vendor_ie_tlv_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    int src_idle_pct  = 17;
    int sink_idle_pct = 78;
    int mismatch_count = 0;
    int results_predicted = 0;
    int bytes_parsed = 0;
    int stall_cycles = 0;

    // parser state mirror
    int          ie_pos;
    logic        hdr_ok;
    logic [8:0]  tag_phase;
    logic [7:0]  tag_kind;
    logic [7:0]  tag_len;
    logic [7:0]  tag_stage [STAGE_DEPTH];
    logic [7:0]  cur_flags1, cur_flags2;
    logic [15:0] cur_mru, cur_framer, cur_freq;
    logic [31:0] kept_version;
    logic        version_seen, name_seen;
    logic [63:0] kept_name_hi, kept_name_lo;

    t_result     ie_results_due [$];
    t_result     result_now;
    logic [7:0]  ie_bytes [$];

    task automatic clear_parse_state();
        ie_pos       = 0;
        hdr_ok       = 1'b1;
        tag_phase    = PH_TYPE;
        tag_kind     = '0;
        tag_len      = '0;
        cur_flags1   = '0;
        cur_flags2   = '0;
        cur_mru      = '0;
        cur_framer   = '0;
        cur_freq     = '0;
        kept_version = '0;
        version_seen = 1'b0;
        name_seen    = 1'b0;
        kept_name_hi = '0;
        kept_name_lo = '0;
    endtask

    task automatic commit_tag();
        int k;
        if (tag_kind == TAG_DATA && tag_len == TAG_DATA_LEN) begin
            cur_flags1 = tag_stage[0];
            cur_flags2 = tag_stage[1];
            cur_mru    = {tag_stage[9], tag_stage[8]};
            cur_framer = {tag_stage[27], tag_stage[26]};
            if (!version_seen) begin
                kept_version = {tag_stage[7], tag_stage[6], tag_stage[5], tag_stage[4]};
                version_seen = 1'b1;
            end
            if (!name_seen && tag_stage[NAME_OFS] != 8'h00) begin
                for (k = 0; k < NAME_HALF; k++) begin
                    kept_name_hi = {kept_name_hi[55:0], tag_stage[NAME_OFS + k]};
                    kept_name_lo = {kept_name_lo[55:0], tag_stage[NAME_OFS + NAME_HALF + k]};
                end
                name_seen = 1'b1;
            end
        end else if (tag_kind == TAG_FREQ && tag_len == TAG_FREQ_LEN) begin
            cur_freq = {tag_stage[1], tag_stage[0]};
        end
    endtask

    task automatic parse_ie_byte(input logic [7:0] b, input logic last);
        int     idx;
        t_result r;
        if (ie_pos < int'(POS_MAX)) begin
            if (ie_pos < HDR_LEN) begin
                if (b != IE_MAGIC[ie_pos]) hdr_ok = 1'b0;
            end else if (tag_phase == PH_TYPE) begin
                tag_kind  = b;
                tag_phase = PH_LEN;
            end else if (tag_phase == PH_LEN) begin
                tag_len = b;
                if (b == 8'h00) begin
                    commit_tag();
                    tag_phase = PH_TYPE;
                end else begin
                    tag_phase = PH_VALUE;
                end
            end else begin
                idx = int'(tag_phase) - int'(PH_VALUE);
                if (idx < STAGE_DEPTH) tag_stage[idx] = b;
                if (idx + 1 >= int'(tag_len)) begin
                    commit_tag();
                    tag_phase = PH_TYPE;
                end else begin
                    tag_phase = tag_phase + 9'd1;
                end
            end
            ie_pos++;
        end
        if (last) begin
            r = '0;
            if (hdr_ok && ie_pos >= HDR_LEN) begin
                r.valid_res        = 1'b1;
                r.flags_first      = cur_flags1;
                r.flags_second     = cur_flags2;
                r.max_receive_unit = cur_mru;
                r.frame_cap        = cur_framer;
                r.frequency        = cur_freq;
                r.version_word     = kept_version;
                r.version_present  = version_seen;
                r.name_high        = kept_name_hi;
                r.name_low         = kept_name_lo;
                r.name_present     = name_seen;
            end
            ie_results_due.push_back(r);
            results_predicted++;
            clear_parse_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        parse_ie_byte(b, last);
    endtask

    task automatic send_element();
        int i;
        if (ie_bytes.size() == 0) ie_bytes.push_back(8'($urandom));
        for (i = 0; i < ie_bytes.size(); i++)
            send_byte(ie_bytes[i], i == ie_bytes.size() - 1);
        bytes_parsed += (ie_bytes.size() > 255) ? 255 : ie_bytes.size();
        ie_bytes.delete();
    endtask

    task automatic push_magic();
        int i;
        for (i = 0; i < HDR_LEN; i++) ie_bytes.push_back(IE_MAGIC[i]);
    endtask

    // fill < 0 gives random value bytes
    task automatic push_tag(input logic [7:0] kind, input int len, input int fill,
                            input bit blank_name);
        int i, base;
        ie_bytes.push_back(kind);
        ie_bytes.push_back(8'(len));
        base = ie_bytes.size();
        for (i = 0; i < len; i++)
            ie_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        if (blank_name && len > NAME_OFS) ie_bytes[base + NAME_OFS] = 8'h00;
    endtask

    task automatic trim_element(input int n);
        while (ie_bytes.size() > n) void'(ie_bytes.pop_back());
    endtask

    task automatic push_random_tag();
        int k;
        k = $urandom_range(99);
        if (k < 45)
            push_tag(TAG_DATA, int'(TAG_DATA_LEN), -1, $urandom_range(3) == 0);
        else if (k < 70)
            push_tag(TAG_FREQ, int'(TAG_FREQ_LEN), -1, 1'b0);
        else if (k < 78)
            if ($urandom_range(1))
                push_tag(TAG_DATA, $urandom_range(1) ? 29 : 31, -1, 1'b0);
            else
                push_tag(TAG_FREQ, $urandom_range(1) ? 1 : 3, -1, 1'b0);
        else if (k < 85)
            push_tag(8'($urandom), 0, -1, 1'b0);
        else
            push_tag(8'($urandom), $urandom_range(40), -1, 1'b0);
    endtask

    task automatic build_random_element();
        int k, n, i;
        k = $urandom_range(99);
        if (k < 2) begin
            n = $urandom_range(240, 300);
            push_magic();
            while (ie_bytes.size() < n) push_random_tag();
            trim_element(n);
        end else if (k < 14) begin
            if ($urandom_range(1)) begin
                n = $urandom_range(1, HDR_LEN);
                for (i = 0; i < n; i++) ie_bytes.push_back(IE_MAGIC[i]);
            end
            n = $urandom_range(0, 12);
            for (i = 0; i < n; i++) ie_bytes.push_back(8'($urandom));
        end else begin
            push_magic();
            if (k < 22) begin
                i = $urandom_range(HDR_LEN - 1);
                ie_bytes[i] = ie_bytes[i] ^ 8'($urandom_range(1, 255));
            end
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++) push_random_tag();
            if ($urandom_range(99) < 15) trim_element($urandom_range(1, ie_bytes.size()));
        end
    endtask

    task automatic test_header_checks();
        int i;
        ie_bytes.push_back(8'hFF);
        send_element();
        for (i = 0; i < HDR_LEN - 1; i++) ie_bytes.push_back(IE_MAGIC[i]);
        send_element();
        push_magic();
        send_element();
        for (i = 0; i < HDR_LEN; i++) begin
            push_magic();
            ie_bytes[i] = ie_bytes[i] ^ 8'hFF;
            push_tag(TAG_FREQ, int'(TAG_FREQ_LEN), -1, 1'b0);
            send_element();
        end
    endtask

    task automatic test_tag_decoding();
        push_magic();
        push_tag(TAG_DATA, int'(TAG_DATA_LEN), 255, 1'b0);
        send_element();
        push_magic();
        push_tag(TAG_DATA, int'(TAG_DATA_LEN), 0, 1'b0);
        send_element();
        // version from the first data tag, name from the first nonblank one
        push_magic();
        push_tag(TAG_DATA, int'(TAG_DATA_LEN), -1, 1'b1);
        push_tag(TAG_DATA, int'(TAG_DATA_LEN), -1, 1'b0);
        push_tag(TAG_DATA, int'(TAG_DATA_LEN), -1, 1'b0);
        push_tag(TAG_FREQ, int'(TAG_FREQ_LEN), -1, 1'b0);
        send_element();
        push_magic();
        push_tag(TAG_FREQ, int'(TAG_FREQ_LEN), 255, 1'b0);
        push_tag(TAG_FREQ, int'(TAG_FREQ_LEN), 0, 1'b0);
        push_tag(TAG_DATA, 0, -1, 1'b0);
        push_tag(TAG_OTHER, int'(TAG_DATA_LEN), -1, 1'b0);
        push_tag(TAG_DATA, 29, -1, 1'b0);
        push_tag(TAG_FREQ, 3, -1, 1'b0);
        push_tag(TAG_FREQ, 1, -1, 1'b0);
        send_element();
        // unfinished tags at the element end
        push_magic();
        push_tag(TAG_FREQ, int'(TAG_FREQ_LEN), -1, 1'b0);
        push_tag(TAG_DATA, int'(TAG_DATA_LEN), -1, 1'b0);
        trim_element(ie_bytes.size() - 1);
        send_element();
        push_magic();
        push_tag(TAG_DATA, int'(TAG_DATA_LEN), -1, 1'b0);
        ie_bytes.push_back(TAG_FREQ);
        send_element();
        push_magic();
        push_tag(TAG_FREQ, int'(TAG_FREQ_LEN), -1, 1'b0);
        ie_bytes.push_back(TAG_FREQ);
        ie_bytes.push_back(TAG_FREQ_LEN);
        send_element();
    endtask

    task automatic test_long_elements();
        // data tag ends on byte 253, a frequency tag straddles the byte cap,
        // tlast lands on a dropped byte
        push_magic();
        push_tag(TAG_FREQ, int'(TAG_FREQ_LEN), -1, 1'b0);
        push_tag(TAG_OTHER, 209, -1, 1'b0);
        push_tag(TAG_DATA, int'(TAG_DATA_LEN), -1, 1'b0);
        push_tag(TAG_FREQ, int'(TAG_FREQ_LEN), -1, 1'b0);
        ie_bytes.push_back(8'hA5);
        send_element();
    endtask

    task automatic test_random_streams();
        int p, bytes_goal, results_goal;
        for (p = 0; p < 3; p++) begin
            src_idle_pct  = (p == 0) ? 17 : (p == 1) ? 78 : 0;
            sink_idle_pct = (p == 0) ? 78 : (p == 1) ? 17 : 0;
            bytes_goal    = bytes_parsed + 40;
            results_goal  = results_predicted + 2;
            while (bytes_parsed < bytes_goal || results_predicted < results_goal) begin
                build_random_element();
                send_element();
            end
        end
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(negedge i_clk)
        i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (ie_results_due.size() == 0) begin
                note_mismatch("unsolicited result", '0, {63'd0, o_m_axis_tuser});
            end else begin
                result_now = ie_results_due.pop_front();
                if (result_now.valid_res !== o_m_axis_tuser)
                    note_mismatch("valid_res", 64'(result_now.valid_res),
                                  64'(o_m_axis_tuser));
                if (result_now.flags_first !== o_m_axis_tdata[7:0])
                    note_mismatch("flags_first", 64'(result_now.flags_first),
                                  64'(o_m_axis_tdata[7:0]));
                if (result_now.flags_second !== o_m_axis_tdata[15:8])
                    note_mismatch("flags_second", 64'(result_now.flags_second),
                                  64'(o_m_axis_tdata[15:8]));
                if (result_now.max_receive_unit !== o_m_axis_tdata[31:16])
                    note_mismatch("max_receive_unit", 64'(result_now.max_receive_unit),
                                  64'(o_m_axis_tdata[31:16]));
                if (result_now.frame_cap !== o_m_axis_tdata[47:32])
                    note_mismatch("frame_cap", 64'(result_now.frame_cap),
                                  64'(o_m_axis_tdata[47:32]));
                if (result_now.frequency !== o_m_axis_tdata[63:48])
                    note_mismatch("frequency", 64'(result_now.frequency),
                                  64'(o_m_axis_tdata[63:48]));
                if (result_now.version_word !== o_m_axis_tdata[95:64])
                    note_mismatch("version_word", 64'(result_now.version_word),
                                  64'(o_m_axis_tdata[95:64]));
                if (result_now.version_present !== o_m_axis_tdata[96])
                    note_mismatch("version_present", 64'(result_now.version_present),
                                  64'(o_m_axis_tdata[96]));
                if (result_now.name_high !== o_m_axis_tdata[160:97])
                    note_mismatch("name_high", result_now.name_high, o_m_axis_tdata[160:97]);
                if (result_now.name_low !== o_m_axis_tdata[224:161])
                    note_mismatch("name_low", result_now.name_low, o_m_axis_tdata[224:161]);
                if (result_now.name_present !== o_m_axis_tdata[225])
                    note_mismatch("name_present", 64'(result_now.name_present),
                                  64'(o_m_axis_tdata[225]));
            end
        end
    end

    // cycles without any transfer on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("** vendor_ie_tlv_parser: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        clear_parse_state();
        foreach (tag_stage[i]) tag_stage[i] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_header_checks();
        test_tag_decoding();
        test_long_elements();
        test_random_streams();

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast  <= 1'b0;
        while (ie_results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && ie_results_due.size() == 0)
            $display("** vendor_ie_tlv_parser: PASSED **");
        else
            $display("** vendor_ie_tlv_parser: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/vie_pkg.sv
rtl/vie_stage.sv
rtl/vie_parse.sv
rtl/vie_out.sv
rtl/vendor_ie_tlv_parser.sv
sim/vendor_ie_tlv_parser_tb.sv
